[sv/tkl_pkg.sv]
// ----------------------------------------------------------------------------
// tkl_pkg: shared constants and types of the top-K largest tracker
// Slot count, field widths, stream widths, opcodes and the slot entry layout.
// ----------------------------------------------------------------------------
package tkl_pkg;

  localparam int unsigned K          = 64;
  localparam int unsigned AW         = (K > 1) ? $clog2(K) : 1;
  localparam int unsigned CW         = $clog2(K + 1);

  localparam int unsigned ID_W       = 32;
  localparam int unsigned SIZE_W     = 48;
  localparam int unsigned RANK_W     = 6;
  localparam int unsigned ENTRY_W    = ID_W + SIZE_W;

  localparam int unsigned IN_DATA_W  = ((ID_W + SIZE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((RANK_W + ID_W + SIZE_W + 7) / 8) * 8;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

[sv/tkl_ram.sv]
// ----------------------------------------------------------------------------
// tkl_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module tkl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/top_k_largest_tracker.sv]
// ----------------------------------------------------------------------------
// top_k_largest_tracker: keeps the K largest (id, size) items seen
// Insert: written straight to the next free slot while slots are free; once full,
//   one RAM read a cycle over all slots for the first minimum, then a conditional write.
// Readout of n items: exchange sort run through the slot RAM, one compare a cycle,
//   result i sent after pass i and held while the output stalls.
// Reset clears the held count and the handshake state; slot contents are left.
// ----------------------------------------------------------------------------
module top_k_largest_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: item_id[31:0], size[79:32]
  input  logic [tkl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: rank[5:0], item_id_res[37:6], size_res[85:38], zero pad[87:86]
  output logic [tkl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);

  import tkl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_LOAD,
    ST_INNER,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         ptr_q;
  logic [AW-1:0]         i_q;
  logic [AW-1:0]         best_q;
  logic [SIZE_W-1:0]     best_sz_q;
  entry_t                new_q;
  entry_t                cur_q;
  logic                  out_valid_q;
  logic [RANK_W-1:0]     out_rank_q;
  entry_t                out_entry_q;
  logic                  out_last_q;

  logic                  in_acc;
  entry_t                in_entry;
  entry_t                rdata;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  entry_t                ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [CW-1:0]         nxt_ptr;
  logic [CW-1:0]         nxt_i;
  logic                  swap;
  logic                  out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_entry.id     = s_axis_tdata_i[ID_W-1:0];
  assign in_entry.size   = s_axis_tdata_i[ID_W+SIZE_W-1:ID_W];

  assign nxt_ptr  = CW'(ptr_q) + CW'(1);
  assign nxt_i    = CW'(i_q) + CW'(1);
  assign swap     = (cur_q.size > rdata.size);
  assign out_free = !out_valid_q || m_axis_tready_i;

  tkl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (K)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = in_entry;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == OP_INSERT) && (count_q < CW'(K))) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
        end
      end
      ST_SCAN: begin
        ram_raddr = ptr_q + AW'(1);
      end
      ST_REPL: begin
        if (best_sz_q < new_q.size) begin
          ram_we    = 1'b1;
          ram_waddr = best_q;
          ram_wdata = new_q;
        end
      end
      ST_LOAD: begin
        ram_raddr = i_q + AW'(1);
      end
      ST_INNER: begin
        // push the current holder down to slot j when it is larger
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q;
          ram_wdata = cur_q;
        end
        ram_raddr = ptr_q + AW'(1);
      end
      ST_EMIT: begin
        ram_raddr = i_q + AW'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      i_q         <= '0;
      best_q      <= '0;
      best_sz_q   <= '0;
      new_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_rank_q  <= '0;
      out_entry_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // drop the sent result; in ST_EMIT the output register is handled below
      if (out_valid_q && m_axis_tready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i == OP_INSERT) begin
              if (count_q < CW'(K)) begin
                count_q <= count_q + CW'(1);
              end else begin
                new_q   <= in_entry;
                ptr_q   <= '0;
                state_q <= ST_SCAN;
              end
            end else if (count_q != '0) begin
              i_q     <= '0;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_SCAN: begin
          // keep the first slot with the smallest size
          if ((ptr_q == '0) || (rdata.size < best_sz_q)) begin
            best_q    <= ptr_q;
            best_sz_q <= rdata.size;
          end
          if (nxt_ptr == CW'(K)) begin
            state_q <= ST_REPL;
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        ST_REPL: begin
          state_q <= ST_IDLE;
        end
        ST_LOAD: begin
          cur_q <= rdata;
          if (nxt_i == count_q) begin
            state_q <= ST_EMIT;
          end else begin
            ptr_q   <= i_q + AW'(1);
            state_q <= ST_INNER;
          end
        end
        ST_INNER: begin
          if (swap) begin
            cur_q <= rdata;
          end
          if (nxt_ptr == count_q) begin
            state_q <= ST_EMIT;
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        ST_EMIT: begin
          // result i is final in cur_q after its pass; hold until the output is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rank_q  <= RANK_W'(i_q);
            out_entry_q <= cur_q;
            out_last_q  <= (nxt_i == count_q);
            if (nxt_i == count_q) begin
              count_q <= '0;
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + AW'(1);
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - RANK_W - ID_W - SIZE_W){1'b0}},
                            out_entry_q.size, out_entry_q.id, out_rank_q};

endmodule
